[src/ctf_pkg.sv]
// ----------------------------------------------------------------------------
// ctf_pkg: shared types and constants of the complementary tilt filter
// Holds the controller states, datapath commands, configuration bundle and
// the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ctf_pkg;

   localparam int ATAN_N = 24;

   localparam logic signed [27:0] ANG_PI   = 28'sd52707179;
   localparam logic signed [21:0] US_SCALE = 22'sd1099512;

   localparam logic [2:0] CSR_ROW_X  = 3'd0;
   localparam logic [2:0] CSR_ROW_Y  = 3'd1;
   localparam logic [2:0] CSR_ROW_Z  = 3'd2;
   localparam logic [2:0] CSR_BIAS   = 3'd3;
   localparam logic [2:0] CSR_WEIGHT = 3'd4;

   typedef enum logic [4:0] {
      S_IDLE, S_MAT, S_RCI, S_RCS, S_RSV, S_SQY, S_SQZ, S_ROOT, S_PCI, S_PCS,
      S_PSV, S_INCP, S_INCH, S_INCL, S_INCS, S_BLA, S_BLB, S_BLS, S_OUT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_MAT, OP_RCINIT, OP_PCINIT, OP_CSTEP, OP_RSAVE,
      OP_PSAVE, OP_SQY, OP_SQZ, OP_ROOT, OP_INCP, OP_INCH, OP_INCL, OP_INCS,
      OP_BLA, OP_BLB, OP_BLS, OP_OUT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       vec;
      logic [1:0] row;
      logic [1:0] col;
      logic [4:0] iter;
      logic       axis;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic [15:0] weight;
      logic [47:0] bias;
      logic [47:0] row_z;
      logic [47:0] row_y;
      logic [47:0] row_x;
   } cfg_type;

   function automatic logic signed [27:0] atan_entry(input logic [4:0] i);
      logic signed [27:0] v;
      case (i)
         5'd0:  v = 28'sd13176795;
         5'd1:  v = 28'sd7778716;
         5'd2:  v = 28'sd4110060;
         5'd3:  v = 28'sd2086331;
         5'd4:  v = 28'sd1047214;
         5'd5:  v = 28'sd524117;
         5'd6:  v = 28'sd262123;
         5'd7:  v = 28'sd131069;
         5'd8:  v = 28'sd65536;
         5'd9:  v = 28'sd32768;
         5'd10: v = 28'sd16384;
         5'd11: v = 28'sd8192;
         5'd12: v = 28'sd4096;
         5'd13: v = 28'sd2048;
         5'd14: v = 28'sd1024;
         5'd15: v = 28'sd512;
         5'd16: v = 28'sd256;
         5'd17: v = 28'sd128;
         5'd18: v = 28'sd64;
         5'd19: v = 28'sd32;
         5'd20: v = 28'sd16;
         5'd21: v = 28'sd8;
         5'd22: v = 28'sd4;
         5'd23: v = 28'sd2;
         default: v = 28'sd0;
      endcase
      return v;
   endfunction

endpackage

[src/ctf_csr.sv]
// ----------------------------------------------------------------------------
// ctf_csr: configuration registers
// Alignment rows, gyro bias and blend weight, written through a plain port.
// ----------------------------------------------------------------------------
module ctf_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [47:0]       csr_wdata,
   output ctf_pkg::cfg_type  cfg
);
   import ctf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_X:  cfg_in.row_x  = csr_wdata;
            CSR_ROW_Y:  cfg_in.row_y  = csr_wdata;
            CSR_ROW_Z:  cfg_in.row_z  = csr_wdata;
            CSR_BIAS:   cfg_in.bias   = csr_wdata;
            CSR_WEIGHT: cfg_in.weight = csr_wdata[15:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_x  <= 48'd16384;
         cfg_ff.row_y  <= 48'd1073741824;
         cfg_ff.row_z  <= 48'd70368744177664;
         cfg_ff.bias   <= 48'd0;
         cfg_ff.weight <= 16'd6554;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/ctf_ctrl.sv]
// ----------------------------------------------------------------------------
// ctf_ctrl: sequencing controller
// Steps the datapath through alignment, two CORDIC passes, the square root,
// the angle increments and the blends, then hands the result to the output.
// ----------------------------------------------------------------------------
module ctf_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  ctf_pkg::status_type  status,
   output ctf_pkg::cmd_type     cmd
);
   import ctf_pkg::*;

   localparam int NSTEPS = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;

   state_type  state_ff, state_in;
   logic       vec_ff;
   logic [1:0] row_ff, col_ff;
   logic [4:0] iter_ff;
   logic       axis_ff;

   logic mat_last, cstep_last, root_last;

   assign mat_last   = vec_ff && (row_ff == 2'd2) && (col_ff == 2'd2);
   assign cstep_last = (iter_ff == 5'(NSTEPS - 1));
   assign root_last  = (iter_ff == 5'd31);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_MAT;
         S_MAT:  if (mat_last) state_in = S_RCI;
         S_RCI:  state_in = S_RCS;
         S_RCS:  if (cstep_last) state_in = S_RSV;
         S_RSV:  state_in = S_SQY;
         S_SQY:  state_in = S_SQZ;
         S_SQZ:  state_in = S_ROOT;
         S_ROOT: if (root_last) state_in = S_PCI;
         S_PCI:  state_in = S_PCS;
         S_PCS:  if (cstep_last) state_in = S_PSV;
         S_PSV:  state_in = S_INCP;
         S_INCP: state_in = S_INCH;
         S_INCH: state_in = S_INCL;
         S_INCL: state_in = S_INCS;
         S_INCS: state_in = S_BLA;
         S_BLA:  state_in = S_BLB;
         S_BLB:  state_in = S_BLS;
         S_BLS:  state_in = axis_ff ? S_OUT : S_INCP;
         S_OUT:  if (!status.out_busy) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.vec  = vec_ff;
      cmd.row  = row_ff;
      cmd.col  = col_ff;
      cmd.iter = iter_ff;
      cmd.axis = axis_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.op = req_tvalid ? OP_LOAD : OP_NONE;
         end
         S_MAT:  cmd.op = OP_MAT;
         S_RCI:  cmd.op = OP_RCINIT;
         S_RCS:  cmd.op = OP_CSTEP;
         S_RSV:  cmd.op = OP_RSAVE;
         S_SQY:  cmd.op = OP_SQY;
         S_SQZ:  cmd.op = OP_SQZ;
         S_ROOT: cmd.op = OP_ROOT;
         S_PCI:  cmd.op = OP_PCINIT;
         S_PCS:  cmd.op = OP_CSTEP;
         S_PSV:  cmd.op = OP_PSAVE;
         S_INCP: cmd.op = OP_INCP;
         S_INCH: cmd.op = OP_INCH;
         S_INCL: cmd.op = OP_INCL;
         S_INCS: cmd.op = OP_INCS;
         S_BLA:  cmd.op = OP_BLA;
         S_BLB:  cmd.op = OP_BLB;
         S_BLS:  cmd.op = OP_BLS;
         S_OUT:  cmd.op = status.out_busy ? OP_NONE : OP_OUT;
         default: cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vec_ff   <= 1'b0;
         row_ff   <= 2'd0;
         col_ff   <= 2'd0;
         iter_ff  <= 5'd0;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_IDLE: begin
               vec_ff  <= 1'b0;
               row_ff  <= 2'd0;
               col_ff  <= 2'd0;
               iter_ff <= 5'd0;
               axis_ff <= 1'b0;
            end
            S_MAT: begin
               if (col_ff == 2'd2) begin
                  col_ff <= 2'd0;
                  if (row_ff == 2'd2) begin
                     row_ff <= 2'd0;
                     vec_ff <= ~vec_ff;
                  end else begin
                     row_ff <= row_ff + 2'd1;
                  end
               end else begin
                  col_ff <= col_ff + 2'd1;
               end
            end
            S_RCS, S_PCS: iter_ff <= cstep_last ? 5'd0 : iter_ff + 5'd1;
            S_ROOT: iter_ff <= iter_ff + 5'd1;
            S_BLS: axis_ff <= ~axis_ff;
            default: ;
         endcase
      end
   end

endmodule

[src/ctf_dpath.sv]
// ----------------------------------------------------------------------------
// ctf_dpath: filter datapath
// Alignment multiply-accumulate, shared CORDIC vectoring unit, bit-serial
// square root, increment and blend arithmetic, estimates and output register.
// ----------------------------------------------------------------------------
module ctf_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  ctf_pkg::cmd_type     cmd,
   input  ctf_pkg::cfg_type     cfg,
   output ctf_pkg::status_type  status,
   input  logic [111:0]         req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata
);
   import ctf_pkg::*;

   logic signed [15:0] acc_ff [3];
   logic signed [16:0] gyr_ff [3];
   logic [15:0]        dt_ff;
   logic signed [34:0] macc_ff;
   logic signed [34:0] av_ff [3];
   logic signed [34:0] gv_ff [3];
   logic signed [37:0] cx_ff, cy_ff;
   logic signed [27:0] cz_ff;
   logic               czero_ff;
   logic signed [24:0] rang_ff, pang_ff;
   logic [63:0]        sq_ff, rv_ff, rr_ff, rbit_ff;
   logic signed [51:0] p_ff;
   logic signed [53:0] t1_ff;
   logic signed [42:0] t2_ff;
   logic signed [29:0] inc_ff;
   logic signed [49:0] bsum_ff;
   logic signed [23:0] roll_est_ff, pitch_est_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;

   // Alignment multiply-accumulate.
   logic [47:0]        mrow;
   logic signed [15:0] ment;
   logic signed [16:0] vval;
   logic signed [32:0] mprod;
   logic signed [34:0] msum;

   always_comb begin
      unique case (cmd.row)
         2'd0:    mrow = cfg.row_x;
         2'd1:    mrow = cfg.row_y;
         default: mrow = cfg.row_z;
      endcase
      unique case (cmd.col)
         2'd0:    ment = $signed(mrow[15:0]);
         2'd1:    ment = $signed(mrow[31:16]);
         default: ment = $signed(mrow[47:32]);
      endcase
      vval  = cmd.vec ? gyr_ff[cmd.col] : 17'(acc_ff[cmd.col]);
      mprod = ment * vval;
      msum  = ((cmd.col == 2'd0) ? 35'sd0 : macc_ff) + 35'(mprod);
   end

   // CORDIC initialization and step.
   logic signed [37:0] yi, xi;
   logic signed [33:0] hx, hy, hz;
   logic signed [33:0] hya, hza;
   logic [31:0]        hy_mag, hz_mag;
   logic signed [37:0] dx, dy;
   logic signed [27:0] zr;
   logic signed [24:0] cang;

   always_comb begin
      hx = av_ff[0][34:1];
      hy = av_ff[1][34:1];
      hz = av_ff[2][34:1];
      hya = (hy < 0) ? -hy : hy;
      hza = (hz < 0) ? -hz : hz;
      hy_mag = hya[31:0];
      hz_mag = hza[31:0];
      if (cmd.op == OP_PCINIT) begin
         yi = 38'(hx);
         xi = $signed({6'd0, rr_ff[31:0]});
      end else begin
         yi = 38'(av_ff[1]);
         xi = 38'(av_ff[2]);
      end
      dx = cy_ff >>> cmd.iter;
      dy = cx_ff >>> cmd.iter;
      zr = (cz_ff + 28'sd4) >>> 3;
      cang = czero_ff ? 25'sd0 : zr[24:0];
   end

   // Square root step.
   logic [63:0] rtry;
   assign rtry = rr_ff + rbit_ff;

   // Increment and blend terms.
   logic signed [34:0] gsel;
   logic signed [31:0] phi;
   logic signed [20:0] plo;
   logic signed [53:0] isum;
   logic signed [16:0] wa;
   logic signed [17:0] wb;
   logic signed [24:0] angsel;
   logic signed [23:0] estsel;
   logic signed [30:0] esum;
   logic signed [41:0] prod_a;
   logic signed [48:0] prod_b;
   logic signed [49:0] bround;
   logic signed [33:0] bv;
   logic signed [23:0] bsat;

   always_comb begin
      gsel   = cmd.axis ? gv_ff[1] : gv_ff[0];
      phi    = p_ff[51:20];
      plo    = $signed({1'b0, p_ff[19:0]});
      isum   = t1_ff + 54'(t2_ff >>> 20);
      wa     = $signed({1'b0, cfg.weight});
      wb     = 18'sd65536 - 18'(wa);
      angsel = cmd.axis ? pang_ff : rang_ff;
      estsel = cmd.axis ? pitch_est_ff : roll_est_ff;
      esum   = 31'(estsel) + 31'(inc_ff);
      prod_a = wa * angsel;
      prod_b = wb * esum;
      bround = bsum_ff + 50'sd32768;
      bv     = bround[49:16];
      if (bv > 34'sd8388607) begin
         bsat = 24'sd8388607;
      end else if (bv < -34'sd8388608) begin
         bsat = -24'sd8388608;
      end else begin
         bsat = bv[23:0];
      end
   end

   function automatic logic [15:0] to_out(input logic signed [23:0] est);
      logic signed [24:0] s;
      logic signed [16:0] v;
      s = 25'(est) + 25'sd128;
      v = s[24:8];
      return (v > 17'sd32767) ? 16'h7fff : v[15:0];
   endfunction

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            for (int k = 0; k < 3; k++) begin
               acc_ff[k] <= $signed(req_tdata[16*k +: 16]);
               gyr_ff[k] <= 17'($signed(req_tdata[16*(3+k) +: 16]))
                            - 17'($signed(cfg.bias[16*k +: 16]));
            end
            dt_ff <= req_tdata[111:96];
         end
         OP_MAT: begin
            macc_ff <= msum;
            if (cmd.col == 2'd2) begin
               if (cmd.vec) gv_ff[cmd.row] <= msum;
               else         av_ff[cmd.row] <= msum;
            end
         end
         OP_RCINIT, OP_PCINIT: begin
            czero_ff <= (xi == 38'sd0) && (yi == 38'sd0);
            if (xi < 0) begin
               cz_ff <= (yi >= 0) ? ANG_PI : -ANG_PI;
               cx_ff <= -xi;
               cy_ff <= -yi;
            end else begin
               cz_ff <= 28'sd0;
               cx_ff <= xi;
               cy_ff <= yi;
            end
         end
         OP_CSTEP: begin
            if (cy_ff >= 0) begin
               cx_ff <= cx_ff + dx;
               cy_ff <= cy_ff - dy;
               cz_ff <= cz_ff + atan_entry(cmd.iter);
            end else begin
               cx_ff <= cx_ff - dx;
               cy_ff <= cy_ff + dy;
               cz_ff <= cz_ff - atan_entry(cmd.iter);
            end
         end
         OP_RSAVE: rang_ff <= cang;
         OP_PSAVE: pang_ff <= -cang;
         OP_SQY:   sq_ff <= hy_mag * hy_mag;
         OP_SQZ: begin
            rv_ff   <= sq_ff + 64'(hz_mag * hz_mag);
            rr_ff   <= 64'd0;
            rbit_ff <= 64'd1 << 62;
         end
         OP_ROOT: begin
            if (rv_ff >= rtry) begin
               rv_ff <= rv_ff - rtry;
               rr_ff <= (rr_ff >> 1) + rbit_ff;
            end else begin
               rr_ff <= rr_ff >> 1;
            end
            rbit_ff <= rbit_ff >> 2;
         end
         OP_INCP: p_ff   <= gsel * $signed({1'b0, dt_ff});
         OP_INCH: t1_ff  <= phi * US_SCALE;
         OP_INCL: t2_ff  <= 43'(plo * US_SCALE);
         OP_INCS: inc_ff <= isum[53:24];
         OP_BLA:  bsum_ff <= 50'(prod_a);
         OP_BLB:  bsum_ff <= bsum_ff + 50'(prod_b);
         OP_OUT:  rsp_data_ff <= {to_out(pitch_est_ff), to_out(roll_est_ff)};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_est_ff  <= 24'sd0;
         pitch_est_ff <= 24'sd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_BLS) begin
            if (cmd.axis) pitch_est_ff <= bsat;
            else          roll_est_ff  <= bsat;
         end
         if (cmd.op == OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

endmodule

[src/imu_complementary_tilt_filter.sv]
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter: complementary roll and pitch estimator
// One sample is processed at a time. The period is set by the shared CORDIC
// unit run twice and the square root that resolves one result bit per cycle.
// Synchronous reset restores identity alignment, zero bias, weight 6554 and
// zero estimates.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, step_time
   input  logic [111:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // roll_angle, pitch_angle
   output logic [31:0]   rsp_tdata,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [47:0]   csr_wdata
);
   import ctf_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   ctf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ctf_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ctf_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[sim/tilt_checker.sv]
// ----------------------------------------------------------------------------
// tilt_checker: predicts and checks the complementary tilt filter results
// Watches the sample and result channels and the register port, keeps its own
// copy of the registers and the roll and pitch estimates, and compares every
// result transfer with the oldest predicted angle pair.
// ----------------------------------------------------------------------------
module tilt_checker #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [111:0]  req_tdata,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [31:0]   rsp_tdata,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [47:0]   csr_wdata,
   output int            fail_count,
   output int            pending_count
);
   import ctf_pkg::*;

   typedef struct {
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
   } angle_pair_type;

   logic [47:0]        row_x, row_y, row_z, bias;
   logic [15:0]        weight;
   longint             roll_est, pitch_est;
   angle_pair_type     angle_queue[$];

   function automatic longint coef(input logic [47:0] w, input int k);
      logic signed [15:0] f;
      f = w[16*k +: 16];
      return longint'(f);
   endfunction

   function automatic longint atan2_fix(input longint y, input longint x);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? longint'(ANG_PI) : -longint'(ANG_PI);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS && i < ATAN_N; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += longint'(atan_entry(5'(i)));
         end else begin
            x -= dx; y += dy; z -= longint'(atan_entry(5'(i)));
         end
      end
      return (z + 4) >>> 3;
   endfunction

   function automatic longint int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b; r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint angle_step(input longint rate, input longint dt);
      longint p, hi, lo;
      p = rate * dt;
      hi = p >>> 20;
      lo = p - hi * (64'sd1 << 20);
      return (hi * longint'(US_SCALE) + ((lo * longint'(US_SCALE)) >>> 20)) >>> 24;
   endfunction

   function automatic longint blend_angle(input longint acc, input longint est,
                                          input longint inc);
      longint a, v;
      a = longint'(weight);
      v = (a * acc + (65536 - a) * (est + inc) + 32768) >>> 16;
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v;
   endfunction

   function automatic logic signed [15:0] out_angle(input longint est);
      longint v;
      v = (est + 128) >>> 8;
      if (v > 32767) v = 32767;
      return 16'(v);
   endfunction

   task automatic predict_sample(input logic [111:0] d);
      longint acc[3], gyr[3], a[3], g[3];
      longint hx, hy, hz, dt, r_acc, p_acc, ay, az;
      angle_pair_type ap;
      for (int k = 0; k < 3; k++) begin
         acc[k] = longint'($signed(d[16*k +: 16]));
         gyr[k] = longint'($signed(d[16*(k+3) +: 16])) - coef(bias, k);
      end
      dt = longint'(d[111:96]);
      for (int r = 0; r < 3; r++) begin
         a[r] = 0; g[r] = 0;
         for (int c = 0; c < 3; c++) begin
            a[r] += coef(r == 0 ? row_x : r == 1 ? row_y : row_z, c) * acc[c];
            g[r] += coef(r == 0 ? row_x : r == 1 ? row_y : row_z, c) * gyr[c];
         end
      end
      r_acc = atan2_fix(a[1], a[2]);
      hx = a[0] >>> 1;
      hy = a[1] >>> 1;
      hz = a[2] >>> 1;
      ay = hy < 0 ? -hy : hy;
      az = hz < 0 ? -hz : hz;
      p_acc = -atan2_fix(hx, int_sqrt(longint'(ay * ay + az * az)));
      roll_est = blend_angle(r_acc, roll_est, angle_step(g[0], dt));
      pitch_est = blend_angle(p_acc, pitch_est, angle_step(g[1], dt));
      ap.roll = out_angle(roll_est);
      ap.pitch = out_angle(pitch_est);
      angle_queue.push_back(ap);
   endtask

   assign pending_count = angle_queue.size();

   always @(posedge clock) begin
      angle_pair_type ap;
      if (reset) begin
         row_x <= 48'd16384;
         row_y <= 48'd1073741824;
         row_z <= 48'd70368744177664;
         bias <= '0;
         weight <= 16'd6554;
         roll_est = 0;
         pitch_est = 0;
         angle_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ROW_X:  row_x <= csr_wdata;
               CSR_ROW_Y:  row_y <= csr_wdata;
               CSR_ROW_Z:  row_z <= csr_wdata;
               CSR_BIAS:   bias <= csr_wdata;
               CSR_WEIGHT: weight <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_sample(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (angle_queue.size() == 0) begin
               $error("result transfer with no sample pending: %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               ap = angle_queue.pop_front();
               if (rsp_tdata[15:0] !== ap.roll || rsp_tdata[31:16] !== ap.pitch) begin
                  if (rsp_tdata[15:0] !== ap.roll)
                     $error("roll_angle expected %0d got %0d", ap.roll,
                            $signed(rsp_tdata[15:0]));
                  if (rsp_tdata[31:16] !== ap.pitch)
                     $error("pitch_angle expected %0d got %0d", ap.pitch,
                            $signed(rsp_tdata[31:16]));
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the complementary tilt filter
// Drives directed and random IMU samples through several register settings,
// with random gaps on the sample side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
   import ctf_pkg::*;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [111:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [31:0]   rsp_tdata;
   logic          csr_we = 1'b0;
   logic [2:0]    csr_index = '0;
   logic [47:0]   csr_wdata = '0;
   int            fail_count, pending_count;
   int            cycle_count = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   imu_complementary_tilt_filter dut (.*);
   tilt_checker checker_i (.*);

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 200);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (n > 0) begin
            rsp_tready <= 1'b0;
            n--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) n = gap_len();
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // The valid stays high after a transfer; settle, or a later call with a gap, drops it.
   task automatic send_sample(input logic [111:0] d, input bit quiet);
      int g;
      g = quiet ? 0 : gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [111:0] sample(input int ax, ay, az, rx, ry, rz, dt);
      return {16'(dt), 16'(rz), 16'(ry), 16'(rx), 16'(az), 16'(ay), 16'(ax)};
   endfunction

   function automatic logic [111:0] rand_sample(input int mode);
      logic [111:0] d;
      d = 112'({$urandom, $urandom, $urandom, $urandom});
      if (mode == 1) begin
         d[15:0] = 16'($signed(16'($urandom_range(0, 4000))) - 2000);
         d[31:16] = 16'($signed(16'($urandom_range(0, 4000))) - 2000);
         d[47:32] = 16'($urandom_range(14000, 18000));
         d[111:96] = 16'($urandom_range(500, 20000));
      end
      return d;
   endfunction

   function automatic logic [47:0] rand_row();
      return {16'($urandom), 16'($urandom), 16'($urandom)};
   endfunction

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_sample(sample(0, 0, 0, 0, 0, 0, 0), 0);
      send_sample(sample(0, 0, -16384, 100, -100, 5, 1000), 0);
      send_sample(sample(16384, 0, 0, 0, 0, 0, 65535), 0);
      send_sample(sample(-16384, 0, 0, 0, 0, 0, 65535), 0);
      send_sample(sample(0, -16384, 0, 32767, 32767, 32767, 65535), 1);
      send_sample(sample(0, 16384, 0, -32768, -32768, -32768, 65535), 1);
      send_sample(sample(32767, 32767, 32767, 32767, 32767, 32767, 65535), 1);
      send_sample(sample(-32768, -32768, -32768, -32768, -32768, -32768, 65535), 1);
      send_sample(sample(-32768, 0, -32768, 1, -1, 0, 1), 0);
      send_sample(sample(0, 0, -1, 0, 0, 0, 0), 0);
      send_sample(sample(5, -3, 16000, 200, 300, 0, 1000), 0);
      settle();
      write_reg(CSR_WEIGHT, 48'hFFFF);
      write_reg(CSR_BIAS, {16'h8000, 16'h7FFF, 16'h8000});
      write_reg(CSR_ROW_X, {16'h8000, 16'h8000, 16'h8000});
      write_reg(CSR_ROW_Y, {16'h7FFF, 16'h7FFF, 16'h7FFF});
      write_reg(CSR_ROW_Z, {16'h8000, 16'h7FFF, 16'h0000});
      send_sample(sample(32767, -32768, 32767, 32767, -32768, 32767, 65535), 0);
      send_sample(sample(-32768, 32767, -32768, -32768, 32767, -32768, 65535), 0);
      send_sample(sample(0, 0, 0, 0, 0, 0, 0), 0);
      settle();
      write_reg(CSR_WEIGHT, 48'h0);
      write_reg(CSR_ROW_X, 48'd16384);
      write_reg(CSR_ROW_Y, 48'd1073741824);
      write_reg(CSR_ROW_Z, 48'd70368744177664);
      write_reg(CSR_BIAS, 48'h0);
      for (int i = 0; i < 8; i++) send_sample(sample(0, 0, 16384, 32767, 32767, 0, 65535), 1);
      for (int i = 0; i < 8; i++)
         send_sample(sample(0, 0, 16384, -32768, -32768, 0, 65535), 1);
      for (int ph = 0; ph < 6; ph++) begin
         settle();
         case (ph)
            0: begin
               write_reg(CSR_WEIGHT, 48'd6554);
               write_reg(CSR_BIAS, 48'h0);
            end
            1: begin
               write_reg(CSR_WEIGHT, 48'($urandom));
               write_reg(CSR_BIAS, {16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                                    16'($urandom_range(0, 200))});
            end
            2: begin
               write_reg(CSR_ROW_X, rand_row());
               write_reg(CSR_ROW_Y, rand_row());
               write_reg(CSR_ROW_Z, rand_row());
               write_reg(CSR_BIAS, rand_row());
            end
            3: begin
               write_reg(CSR_ROW_X, {16'd0, 16'd16384, 16'd0});
               write_reg(CSR_ROW_Y, 48'd16384);
               write_reg(CSR_ROW_Z, {16'hC000, 16'd0, 16'd0});
               write_reg(CSR_WEIGHT, 48'd1);
            end
            4: write_reg(CSR_WEIGHT, 48'd65535);
            default: begin
               write_reg(CSR_ROW_X, 48'd16384);
               write_reg(CSR_ROW_Y, 48'd1073741824);
               write_reg(CSR_ROW_Z, 48'd70368744177664);
               write_reg(CSR_WEIGHT, 48'd3000);
            end
         endcase
         for (int i = 0; i < 90; i++)
            send_sample(rand_sample($urandom_range(0, 2) != 0 ? 1 : 0), $urandom_range(0, 4) == 0);
      end
      settle();
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
